@@ hw/rtl/mbe_pkg.sv @@
// shared types, constants and helpers for the mandelbrot escape-time engine
package mbe_pkg;

    localparam int FRAC_BITS = 28;
    localparam int COL_W     = 12;
    localparam int CNT_W     = 20;
    localparam int CRD_W     = 32;
    localparam int Z_W       = 36;
    localparam int MUL_W     = 30;
    localparam int SQ_W      = 32;
    localparam int XY_W      = 33;
    localparam int SUM_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int MAX_DIM   = 4096;

    localparam longint TWO_RAW_I  = 64'sd1 <<< (FRAC_BITS + 1);
    localparam longint FOUR_RAW_I = 64'sd1 <<< (FRAC_BITS + 2);

    localparam logic signed [Z_W-1:0]  TWO_RAW     = Z_W'(TWO_RAW_I);
    localparam logic signed [Z_W-1:0]  NEG_TWO_RAW = Z_W'(-TWO_RAW_I);
    localparam logic signed [XY_W-1:0] FOUR_RAW    = XY_W'(FOUR_RAW_I);

    localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
    localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ITER_LIMIT  = 3'd0,
        CFG_LEFT_EDGE   = 3'd1,
        CFG_COLUMN_STEP = 3'd2,
        CFG_BOTTOM_EDGE = 3'd3,
        CFG_ROW_STEP    = 3'd4
    } t_cfg_idx;

    // controller to datapath
    typedef struct packed {
        logic load_pix;
        logic init;
        logic mul;
        logic step;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic fine_esc;
        logic step_done;
    } t_dp_sts;

    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
        logic signed [Z_W-1:0] r;
        if (v > SUM_W'(Z_MAX)) begin
            r = Z_MAX;
        end else if (v < SUM_W'(Z_MIN)) begin
            r = Z_MIN;
        end else begin
            r = Z_W'(v);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/mandelbrot_escape_time_top.sv @@
// top level of the mandelbrot escape-time pixel engine
// One pixel (column, row) is taken at a time. Its point c is formed first,
// then each iteration of z = z^2 + c runs as a product step for the
// three registered 30x30 products and an update step for the add, clamp and
// tests. Escape is also found from the squares of the last z, after one more
// product step; this multiply/update loop sets the rate. The result sits in an
// output register, so the next pixel may be accepted while the previous count
// waits to be taken.
module mandelbrot_escape_time_top
    import mbe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CRD_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [COL_W-1:0]     i_pixel_col,
    input  logic [COL_W-1:0]     i_pixel_row,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CNT_W-1:0]     o_iteration_count
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    mbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mbe_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_pixel_col       (i_pixel_col),
        .i_pixel_row       (i_pixel_row),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_iteration_count (o_iteration_count)
    );

endmodule

@@ hw/rtl/mbe_dp.sv @@
// datapath: config registers, c generation, z iteration and result register
module mbe_dp
    import mbe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CRD_W-1:0]     i_cfg_data,
    input  logic [COL_W-1:0]     i_pixel_col,
    input  logic [COL_W-1:0]     i_pixel_row,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic [CNT_W-1:0]     o_iteration_count
);

    logic [CNT_W-1:0]        r_iter_limit;
    logic signed [CRD_W-1:0] r_left_edge;
    logic signed [CRD_W-1:0] r_column_step;
    logic signed [CRD_W-1:0] r_bottom_edge;
    logic signed [CRD_W-1:0] r_row_step;

    logic [COL_W-1:0]        r_col;
    logic [COL_W-1:0]        r_row;
    logic signed [Z_W-1:0]   r_c_re;
    logic signed [Z_W-1:0]   r_c_im;
    logic signed [Z_W-1:0]   r_z_re;
    logic signed [Z_W-1:0]   r_z_im;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [SQ_W-1:0]  r_xx;
    logic signed [SQ_W-1:0]  r_yy;
    logic signed [XY_W-1:0]  r_xy2;
    logic [CNT_W-1:0]        r_out_cnt;

    logic signed [COL_W+CRD_W:0]   prod_re;
    logic signed [COL_W+CRD_W:0]   prod_im;
    logic signed [SUM_W-1:0]       csum_re;
    logic signed [SUM_W-1:0]       csum_im;
    logic signed [MUL_W-1:0]       x;
    logic signed [MUL_W-1:0]       y;
    logic signed [2*MUL_W-1:0]     p_xx;
    logic signed [2*MUL_W-1:0]     p_yy;
    logic signed [2*MUL_W-1:0]     p_xy;
    logic signed [SUM_W-1:0]       zsum_re;
    logic signed [SUM_W-1:0]       zsum_im;
    logic signed [Z_W-1:0]         n_z_re;
    logic signed [Z_W-1:0]         n_z_im;
    logic [CNT_W-1:0]              n_cnt;
    logic signed [XY_W-1:0]        mag_sum;
    logic                          coarse_esc;
    logic                          limit_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter_limit  <= CNT_W'(1);
            r_left_edge   <= '0;
            r_column_step <= '0;
            r_bottom_edge <= '0;
            r_row_step    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ITER_LIMIT:  r_iter_limit  <= i_cfg_data[CNT_W-1:0];
                CFG_LEFT_EDGE:   r_left_edge   <= i_cfg_data;
                CFG_COLUMN_STEP: r_column_step <= i_cfg_data;
                CFG_BOTTOM_EDGE: r_bottom_edge <= i_cfg_data;
                CFG_ROW_STEP:    r_row_step    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // c = index * step + edge, exact before clamping
    assign prod_re = $signed({1'b0, r_col}) * r_column_step;
    assign prod_im = $signed({1'b0, r_row}) * r_row_step;
    assign csum_re = SUM_W'(prod_re) + SUM_W'(r_left_edge);
    assign csum_im = SUM_W'(prod_im) + SUM_W'(r_bottom_edge);

    // z stays inside +-2.0 while iterating, so the low bits carry its value
    assign x    = r_z_re[MUL_W-1:0];
    assign y    = r_z_im[MUL_W-1:0];
    assign p_xx = x * x;
    assign p_yy = y * y;
    assign p_xy = x * y;

    assign zsum_re = SUM_W'(r_xx) - SUM_W'(r_yy) + SUM_W'(r_c_re);
    assign zsum_im = SUM_W'(r_xy2) + SUM_W'(r_c_im);
    assign n_z_re  = sat_z(zsum_re);
    assign n_z_im  = sat_z(zsum_im);
    assign n_cnt   = r_cnt + CNT_W'(1);

    assign coarse_esc = (n_z_re >= TWO_RAW) || (n_z_re <= NEG_TWO_RAW) ||
                        (n_z_im >= TWO_RAW) || (n_z_im <= NEG_TWO_RAW);
    assign limit_hit  = n_cnt >= r_iter_limit;
    assign mag_sum    = XY_W'(r_xx) + XY_W'(r_yy);

    // squares of the current z decide escape of the previous update
    assign o_sts.fine_esc  = mag_sum >= FOUR_RAW;
    assign o_sts.step_done = limit_hit || coarse_esc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pix) begin
            r_col <= COL_W'(32'(i_pixel_col) % MAX_DIM);
            r_row <= COL_W'(32'(i_pixel_row) % MAX_DIM);
        end
        if (i_cmd.init) begin
            r_c_re <= sat_z(csum_re);
            r_c_im <= sat_z(csum_im);
            r_z_re <= '0;
            r_z_im <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.step) begin
            r_z_re <= n_z_re;
            r_z_im <= n_z_im;
            r_cnt  <= n_cnt;
        end
        if (i_cmd.mul) begin
            r_xx  <= SQ_W'(p_xx >>> FRAC_BITS);
            r_yy  <= SQ_W'(p_yy >>> FRAC_BITS);
            r_xy2 <= XY_W'(p_xy >>> (FRAC_BITS - 1));
        end
        if (i_cmd.out_load) begin
            r_out_cnt <= r_cnt;
        end
    end

    assign o_iteration_count = r_out_cnt;

endmodule

@@ hw/rtl/mbe_ctrl.sv @@
// controller: sequences pixel load, c generation, iteration and result handoff
module mbe_ctrl
    import mbe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CGEN = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_STEP = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_pix = 1'b1;
                    n_state        = ST_CGEN;
                end
            end
            ST_CGEN: begin
                o_cmd.init = 1'b1;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_STEP;
            end
            ST_STEP: begin
                if (i_sts.fine_esc) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = i_sts.step_done ? ST_FIN : ST_MUL;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_accept_to_cgen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_CGEN))
        else $error("accepted pixel did not start c generation");

    a_mul_then_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> (r_state == ST_STEP))
        else $error("product stage not followed by update");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FIN))
        else $error("result raised outside finish state");
`endif

endmodule
